// File: rtl/lfpd_pkg.sv
// shared types, constants and microcode table of the line-follow pid drive
package lfpd_pkg;

   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int MS_W      = 16;
   localparam int SPEED_W   = 8;
   localparam int DRIVE_W   = 16;
   localparam int THRESH_W  = 10;

   localparam int ERR_DIVISOR   = 200;
   localparam int MS_PER_SECOND = 1000;
   localparam int SPEED_MAX     = 255;

   // shared divider: 64-bit dividend, 16-bit divisor, four quotient bits a cycle
   localparam int DVD_W          = 64;
   localparam int DVS_W          = 16;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_CYCLES     = DVD_W / DIV_RADIX_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_DARK_THRESHOLD = 3'd3,
      CSR_CRUISE_LEVEL   = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [31:0]         gain_p;
      logic [31:0]         gain_i;
      logic [31:0]         gain_d;
      logic [THRESH_W-1:0] dark_threshold;
      logic [SPEED_W-1:0]  cruise_level;
      logic [7:0]          integral_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:         32'd1310720,
      gain_i:         32'd3277,
      gain_d:         32'd655,
      dark_threshold: 10'd800,
      cruise_level:   8'd120,
      integral_limit: 8'd100
   };

   typedef struct packed {
      logic [SPEED_W-1:0]        left_level;
      logic [SPEED_W-1:0]        right_level;
      logic signed [DRIVE_W-1:0] drive_value;
      logic                      zero_interval;
   } rsp_data_type;

   typedef enum logic [3:0] {
      OP_ERR_PREP,
      OP_WAIT,
      OP_ERR_DIV,
      OP_MUL_ET,
      OP_SUM,
      OP_MUL_P,
      OP_TOT_P,
      OP_MUL_I,
      OP_DIV_I,
      OP_TOT_I,
      OP_MUL_K,
      OP_MUL_D,
      OP_DIV_D,
      OP_TOT_D,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_DARK,
      COND_DIV_BUSY,
      COND_MS_ZERO
   } cond_type;

   localparam int STEP_W      = 5;
   localparam int UCODE_DEPTH = 17;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_ERR_WAIT = 5'd1;
   localparam step_type STEP_MUL_ET   = 5'd3;
   localparam step_type STEP_I_WAIT   = 5'd9;
   localparam step_type STEP_D_WAIT   = 5'd14;
   localparam step_type STEP_FINISH   = 5'd16;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   run;
      logic   load;
   } ctrl_type;

   typedef struct packed {
      logic dark;
      logic div_busy;
      logic ms_zero;
   } status_type;

   // control store: one word per step, jump taken when the condition holds
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      w = '{op: OP_FINISH, cond: COND_NONE, target: '0};
      case (s)
         5'd0:  w = '{op: OP_ERR_PREP, cond: COND_DARK,     target: STEP_MUL_ET};
         5'd1:  w = '{op: OP_WAIT,     cond: COND_DIV_BUSY, target: STEP_ERR_WAIT};
         5'd2:  w = '{op: OP_ERR_DIV,  cond: COND_NONE,     target: '0};
         5'd3:  w = '{op: OP_MUL_ET,   cond: COND_NONE,     target: '0};
         5'd4:  w = '{op: OP_SUM,      cond: COND_NONE,     target: '0};
         5'd5:  w = '{op: OP_MUL_P,    cond: COND_NONE,     target: '0};
         5'd6:  w = '{op: OP_TOT_P,    cond: COND_NONE,     target: '0};
         5'd7:  w = '{op: OP_MUL_I,    cond: COND_NONE,     target: '0};
         5'd8:  w = '{op: OP_DIV_I,    cond: COND_NONE,     target: '0};
         5'd9:  w = '{op: OP_WAIT,     cond: COND_DIV_BUSY, target: STEP_I_WAIT};
         5'd10: w = '{op: OP_TOT_I,    cond: COND_NONE,     target: '0};
         5'd11: w = '{op: OP_MUL_K,    cond: COND_MS_ZERO,  target: STEP_FINISH};
         5'd12: w = '{op: OP_MUL_D,    cond: COND_NONE,     target: '0};
         5'd13: w = '{op: OP_DIV_D,    cond: COND_NONE,     target: '0};
         5'd14: w = '{op: OP_WAIT,     cond: COND_DIV_BUSY, target: STEP_D_WAIT};
         5'd15: w = '{op: OP_TOT_D,    cond: COND_NONE,     target: '0};
         5'd16: w = '{op: OP_FINISH,   cond: COND_NONE,     target: '0};
         default: w = '{op: OP_FINISH, cond: COND_NONE, target: '0};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/lfpd_if.sv
// request and response channel interfaces of the line-follow pid drive
interface lfpd_req_if #(parameter int SAMPLE_BITS = 10);
   logic                         valid;
   logic                         ready;
   logic [SAMPLE_BITS-1:0]       left_sample;
   logic [SAMPLE_BITS-1:0]       right_sample;
   logic [lfpd_pkg::MS_W-1:0]    elapsed_ms;

   modport source (output valid, left_sample, right_sample, elapsed_ms, input ready);
   modport sink (input valid, left_sample, right_sample, elapsed_ms, output ready);
endinterface

interface lfpd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lfpd_pkg::SPEED_W-1:0]        left_level;
   logic [lfpd_pkg::SPEED_W-1:0]        right_level;
   logic signed [lfpd_pkg::DRIVE_W-1:0] drive_value;
   logic                                zero_interval;

   modport source (output valid, left_level, right_level, drive_value, zero_interval,
                   input ready);
   modport sink (input valid, left_level, right_level, drive_value, zero_interval,
                 output ready);
endinterface

// File: rtl/line_follow_pid_drive.sv
// top level of the line-follow pid drive: csr bank, sequencer and datapath
// One word at a time: after a request word is taken the microcode program runs
// and then the response word appears; the program is shorter when a sensor sees
// the dark line (the error division is skipped) or when elapsed_ms is zero (the
// derivative is skipped). The run time is set by the shared divider, which yields
// four quotient bits a cycle and is run for the error, the integral scaling and
// the derivative. The last step holds while an earlier response word still waits
// to be taken. A new request word is taken in the cycle after the program ends,
// even while the last response word still waits to be taken.
// Registers may be written only while the block is idle.
module line_follow_pid_drive #(
   parameter int SAMPLE_BITS    = 10,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   lfpd_req_if.sink                           req_chan,
   lfpd_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_W-1:0]         csr_wdata
);
   import lfpd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   ctrl_type     ctrl;
   status_type   status;
   rsp_data_type rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata;
            CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata;
            CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata;
            CSR_DARK_THRESHOLD: cfg_in.dark_threshold = csr_wdata[THRESH_W-1:0];
            CSR_CRUISE_LEVEL:   cfg_in.cruise_level   = csr_wdata[SPEED_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfpd_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   lfpd_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .cfg          (cfg_ff),
      .left_sample  (req_chan.left_sample),
      .right_sample (req_chan.right_sample),
      .elapsed_ms   (req_chan.elapsed_ms),
      .rsp_data     (rsp_data)
   );

   assign rsp_chan.left_level    = rsp_data.left_level;
   assign rsp_chan.right_level   = rsp_data.right_level;
   assign rsp_chan.drive_value   = rsp_data.drive_value;
   assign rsp_chan.zero_interval = rsp_data.zero_interval;

endmodule

// File: rtl/lfpd_divider.sv
// shared unsigned restoring divider, four quotient bits per cycle
module lfpd_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lfpd_pkg::DVD_W-1:0]     dividend,
   input  logic [lfpd_pkg::DVS_W-1:0]     divisor,
   output logic                           busy,
   output logic [lfpd_pkg::DVD_W-1:0]     quotient
);
   import lfpd_pkg::*;

   localparam int CNT_W = $clog2(DIV_CYCLES);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   always_comb begin
      logic [DVD_W-1:0] q;
      logic [DVS_W:0]   r;
      q = quo_ff;
      r = rem_ff;
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
         r = {r[DVS_W-1:0], q[DVD_W-1]};
         q = {q[DVD_W-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r    = r - {1'b0, dvs_ff};
            q[0] = 1'b1;
         end
      end

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_CYCLES - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = q;
         rem_in  = r;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == '0 && !start |=> !busy_ff)
      else $error("divider ran past its last cycle");

endmodule

// File: rtl/lfpd_datapath.sv
// pid datapath: operand registers, one multiplier, shared divider, output word
module lfpd_datapath #(
   parameter int SAMPLE_BITS    = 10,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfpd_pkg::ctrl_type            ctrl,
   output lfpd_pkg::status_type          status,
   input  lfpd_pkg::cfg_type             cfg,
   input  logic [SAMPLE_BITS-1:0]        left_sample,
   input  logic [SAMPLE_BITS-1:0]        right_sample,
   input  logic [lfpd_pkg::MS_W-1:0]     elapsed_ms,
   output lfpd_pkg::rsp_data_type        rsp_data
);
   import lfpd_pkg::*;

   localparam int ERR_W  = (SAMPLE_BITS - 6 > 3) ? SAMPLE_BITS - 6 : 3;
   localparam int DIFF_W = ERR_W + 1;
   localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
   localparam int MUL_W  = 33;

   localparam logic signed [33:0] SUM_MAX   = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SUM_MIN   = 34'sh3_8000_0000;
   localparam logic signed [63:0] FRAC_RND  = (64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1;
   localparam logic signed [63:0] DRIVE_HI  = 64'sd32767;
   localparam logic signed [63:0] DRIVE_LO  = -64'sd32768;
   localparam logic signed [63:0] SPEED_TOP = 64'(SPEED_MAX);

   logic [SAMPLE_BITS-1:0]     left_ff, left_in, right_ff, right_in;
   logic [MS_W-1:0]            ms_ff, ms_in;
   logic signed [ERR_W-1:0]    err_ff, err_in, last_err_ff, last_err_in;
   logic signed [31:0]         sum_ff, sum_in;
   logic signed [63:0]         prod_ff, prod_in, total_ff, total_in;
   logic                       div_neg_ff, div_neg_in;
   rsp_data_type               out_ff, out_in;

   logic                       ldark, rdark;
   logic signed [SAMPLE_BITS:0] diff_lr;
   logic [SAMPLE_BITS-1:0]     abs_lr;
   logic signed [ERR_W-1:0]    err_dark;
   logic signed [DIFF_W-1:0]   diff_e;
   logic signed [MUL_W-1:0]    sum_ext, sum_abs, mul_a, mul_b;
   logic signed [2*MUL_W-1:0]  mul_p;
   logic                       mul_en;
   logic signed [33:0]         sum_wide;
   logic                       div_start, div_busy;
   logic [DVD_W-1:0]           div_dividend, div_q;
   logic [DVS_W-1:0]           div_divisor;
   logic signed [63:0]         q_signed, lim, mag, base_q, drive_t;

   function automatic logic [SPEED_W-1:0] speed_of(input logic signed [63:0] v);
      logic signed [63:0] w;
      w = v >>> GAIN_FRAC_BITS;
      if (v < 0) return '0;
      else if (w > SPEED_TOP) return SPEED_W'(SPEED_MAX);
      else return w[SPEED_W-1:0];
   endfunction

   assign ldark    = CMP_W'(left_ff) > CMP_W'(cfg.dark_threshold);
   assign rdark    = CMP_W'(right_ff) > CMP_W'(cfg.dark_threshold);
   assign diff_lr  = $signed({1'b0, right_ff}) - $signed({1'b0, left_ff});
   assign abs_lr   = diff_lr[SAMPLE_BITS] ? SAMPLE_BITS'(-diff_lr) : SAMPLE_BITS'(diff_lr);
   // both dark reads as centered on the line
   assign err_dark = rdark ? (ldark ? '0 : ERR_W'(2)) : -ERR_W'(2);
   assign diff_e   = DIFF_W'(err_ff) - DIFF_W'(last_err_ff);
   assign sum_ext  = MUL_W'(sum_ff);
   assign sum_abs  = sum_ext[MUL_W-1] ? -sum_ext : sum_ext;
   assign sum_wide = 34'(sum_ff) + $signed(prod_ff[33:0]);
   assign q_signed = div_neg_ff ? -$signed(div_q) : $signed(div_q);
   assign lim      = 64'(cfg.integral_limit) <<< GAIN_FRAC_BITS;
   assign mag      = ($signed(div_q) > lim) ? lim : $signed(div_q);
   assign base_q   = 64'(cfg.cruise_level) <<< GAIN_FRAC_BITS;
   // truncate toward zero
   assign drive_t  = total_ff[63] ? ((total_ff + FRAC_RND) >>> GAIN_FRAC_BITS)
                                  : (total_ff >>> GAIN_FRAC_BITS);
   assign mul_p    = mul_a * mul_b;

   // multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (ctrl.op)
         OP_MUL_ET: begin
            mul_a  = MUL_W'(err_ff);
            mul_b  = $signed(MUL_W'(ms_ff));
            mul_en = 1'b1;
         end
         OP_MUL_P: begin
            mul_a  = $signed(MUL_W'(cfg.gain_p));
            mul_b  = MUL_W'(err_ff);
            mul_en = 1'b1;
         end
         OP_MUL_I: begin
            mul_a  = $signed(MUL_W'(cfg.gain_i));
            mul_b  = sum_abs;
            mul_en = 1'b1;
         end
         OP_MUL_K: begin
            mul_a  = MUL_W'(diff_e);
            mul_b  = $signed(MUL_W'(MS_PER_SECOND));
            mul_en = 1'b1;
         end
         OP_MUL_D: begin
            mul_a  = $signed(MUL_W'(cfg.gain_d));
            mul_b  = $signed(prod_ff[MUL_W-1:0]);
            mul_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      ms_in        = ms_ff;
      err_in       = err_ff;
      last_err_in  = last_err_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      div_neg_in   = div_neg_ff;
      out_in       = out_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      if (ctrl.load) begin
         left_in  = left_sample;
         right_in = right_sample;
         ms_in    = elapsed_ms;
      end

      if (ctrl.run) begin
         if (mul_en) prod_in = mul_p[63:0];
         case (ctrl.op)
            OP_ERR_PREP: begin
               err_in       = err_dark;
               div_start    = 1'b1;
               div_dividend = DVD_W'(abs_lr);
               div_divisor  = DVS_W'(ERR_DIVISOR);
               div_neg_in   = diff_lr[SAMPLE_BITS];
            end
            OP_ERR_DIV: err_in = ERR_W'(q_signed);
            OP_SUM: begin
               if (sum_wide > SUM_MAX) sum_in = SUM_MAX[31:0];
               else if (sum_wide < SUM_MIN) sum_in = SUM_MIN[31:0];
               else sum_in = sum_wide[31:0];
            end
            OP_TOT_P: total_in = prod_ff;
            OP_DIV_I: begin
               div_start    = 1'b1;
               div_dividend = prod_ff;
               div_divisor  = DVS_W'(MS_PER_SECOND);
               div_neg_in   = sum_ff[31];
            end
            OP_TOT_I: total_in = total_ff + (div_neg_ff ? -mag : mag);
            OP_DIV_D: begin
               div_start    = 1'b1;
               div_dividend = prod_ff[63] ? DVD_W'(-prod_ff) : DVD_W'(prod_ff);
               div_divisor  = ms_ff;
               div_neg_in   = prod_ff[63];
            end
            OP_TOT_D: total_in = total_ff + q_signed;
            OP_FINISH: begin
               out_in.left_level    = speed_of(base_q + total_ff);
               out_in.right_level   = speed_of(base_q - total_ff);
               if (drive_t > DRIVE_HI) out_in.drive_value = DRIVE_HI[DRIVE_W-1:0];
               else if (drive_t < DRIVE_LO) out_in.drive_value = DRIVE_LO[DRIVE_W-1:0];
               else out_in.drive_value = drive_t[DRIVE_W-1:0];
               out_in.zero_interval = (ms_ff == '0);
               last_err_in          = err_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         last_err_ff <= '0;
      end else begin
         sum_ff      <= sum_in;
         last_err_ff <= last_err_in;
      end
      left_ff    <= left_in;
      right_ff   <= right_in;
      ms_ff      <= ms_in;
      err_ff     <= err_in;
      prod_ff    <= prod_in;
      total_ff   <= total_in;
      div_neg_ff <= div_neg_in;
      out_ff     <= out_in;
   end

   lfpd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign status.dark     = ldark | rdark;
   assign status.div_busy = div_busy;
   assign status.ms_zero  = (ms_ff == '0);
   assign rsp_data        = out_ff;

endmodule

// File: rtl/lfpd_sequencer.sv
// microcode sequencer: step counter, control store, jumps and channel handshake
module lfpd_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  lfpd_pkg::status_type  status,
   output lfpd_pkg::ctrl_type    ctrl
);
   import lfpd_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   ucode_type word;
   logic      jump, req_fire, stall, run, fin_fire;

   always_comb begin
      word = ucode_rom(step_ff);
      unique case (word.cond)
         COND_NONE:     jump = 1'b0;
         COND_DARK:     jump = status.dark;
         COND_DIV_BUSY: jump = status.div_busy;
         COND_MS_ZERO:  jump = status.ms_zero;
      endcase

      req_fire = req_valid && (state_ff == ST_IDLE);
      // last step waits while the previous word still sits in the output register
      stall    = (word.op == OP_FINISH) && rsp_valid_ff && !rsp_ready;
      run      = (state_ff == ST_RUN) && !stall;
      fin_fire = run && (word.op == OP_FINISH);

      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = fin_fire || (rsp_valid_ff && !rsp_ready);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (fin_fire) begin
               state_in = ST_IDLE;
               step_in  = '0;
            end else if (run) begin
               step_in = jump ? word.target : step_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign ctrl.op   = word.op;
   assign ctrl.run  = run;
   assign ctrl.load = req_fire;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_RUN && step_ff == '0)
      else $error("accepted word did not start the program");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> rsp_valid_ff)
      else $error("finished word not presented");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> step_ff < STEP_W'(UCODE_DEPTH))
      else $error("step counter left the control store");

endmodule
